// File: hw/rtl/ffd_pkg.sv
package ffd_pkg;

    localparam int unsigned AXIS_W     = 16;
    localparam int unsigned SQ_W       = 31;
    localparam int unsigned SUM_W      = 32;
    localparam int unsigned THR_W      = 32;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned S_TDATA_W  = 48;
    localparam int unsigned M_TDATA_W  = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD_SQ     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD_SQ    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FREEFALL_COUNT_LIMIT = 2'd2;

    localparam logic [THR_W-1:0] LOW_THRESHOLD_SQ_RESET     = 32'd1048576;
    localparam logic [THR_W-1:0] HIGH_THRESHOLD_SQ_RESET    = 32'd51380224;
    localparam logic [CNT_W-1:0] FREEFALL_COUNT_LIMIT_RESET = 8'd10;
    localparam logic [CNT_W-1:0] CNT_MAX                    = 8'd255;

    typedef struct packed {
        logic [SQ_W-1:0] sq_x;
        logic [SQ_W-1:0] sq_y;
        logic [SQ_W-1:0] sq_z;
    } ffd_squares_t;

    typedef struct packed {
        logic [THR_W-1:0] low_threshold_sq;
        logic [THR_W-1:0] high_threshold_sq;
        logic [CNT_W-1:0] freefall_count_limit;
    } ffd_cfg_t;

endpackage

// File: hw/rtl/ffd_square.sv
module ffd_square (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  logic                           advance,
    input  logic [ffd_pkg::AXIS_W-1:0]     accel_x,
    input  logic [ffd_pkg::AXIS_W-1:0]     accel_y,
    input  logic [ffd_pkg::AXIS_W-1:0]     accel_z,
    output logic                           sq_valid,
    output ffd_pkg::ffd_squares_t          squares
);
    import ffd_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    ffd_squares_t         squares_reg;
    logic signed [2*AXIS_W-1:0] prod_x;
    logic signed [2*AXIS_W-1:0] prod_y;
    logic signed [2*AXIS_W-1:0] prod_z;

    assign prod_x = $signed(accel_x) * $signed(accel_x);
    assign prod_y = $signed(accel_y) * $signed(accel_y);
    assign prod_z = $signed(accel_z) * $signed(accel_z);

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            squares_reg.sq_x <= prod_x[SQ_W-1:0];
            squares_reg.sq_y <= prod_y[SQ_W-1:0];
            squares_reg.sq_z <= prod_z[SQ_W-1:0];
        end
    end

    assign sq_valid = valid_reg;
    assign squares  = squares_reg;

endmodule

// File: hw/rtl/ffd_decide.sv
module ffd_decide (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  sq_valid,
    input  ffd_pkg::ffd_squares_t squares,
    input  ffd_pkg::ffd_cfg_t     cfg,
    output logic                  res_valid,
    output logic                  fall_detected,
    output logic                  freefall_active
);
    import ffd_pkg::*;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             fall_reg;
    logic             fall_next;
    logic             active_reg;
    logic             active_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             flag_reg;
    logic             flag_next;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count_inc;

    assign sum = SUM_W'(squares.sq_x) + SUM_W'(squares.sq_y) + SUM_W'(squares.sq_z);
    assign count_inc = (count_reg == CNT_MAX) ? CNT_MAX : count_reg + CNT_W'(1);

    always_comb begin
        count_next     = count_reg;
        flag_next      = flag_reg;
        fall_next      = fall_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = sq_valid;
            if (sq_valid) begin
                fall_next = 1'b0;
                if (sum < cfg.low_threshold_sq) begin
                    count_next = count_inc;
                    flag_next  = flag_reg | (count_inc > cfg.freefall_count_limit);
                end else if ((sum > cfg.high_threshold_sq) && flag_reg) begin
                    fall_next  = 1'b1;
                    count_next = '0;
                    flag_next  = 1'b0;
                end else begin
                    count_next = '0;
                    flag_next  = 1'b0;
                end
                active_next = flag_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            flag_reg      <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            flag_reg      <= flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        fall_reg   <= fall_next;
        active_reg <= active_next;
    end

    assign res_valid       = out_valid_reg;
    assign fall_detected   = fall_reg;
    assign freefall_active = active_reg;

endmodule

// File: hw/rtl/freefall_impact_fall_detector_unit.sv
// channel  | direction | handshake               | payload
// s_       | in        | s_tvalid / s_tready     | s_tdata: accel_x, accel_y, accel_z
// m_       | out       | m_tvalid / m_tready     | m_tdata: fall_detected, freefall_active
// cfg_     | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one sample accepted per cycle unless back-pressure stalls intake; its result is registered
// first in the squares register and then in the result register
// the low-run count and freefall flag live next to the result register
// reset: synchronous active-low aresetn clears counter, flag and valids
// a stalled result holds in the output register; intake stops only when both stages are full
module freefall_impact_fall_detector_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
    input  logic [ffd_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] fall_detected, [1] freefall_active, [7:2] zero
    output logic [ffd_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ffd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ffd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ffd_pkg::*;

    ffd_cfg_t     cfg_reg;
    ffd_cfg_t     cfg_next;
    ffd_squares_t squares;
    logic         sq_valid;
    logic         advance;
    logic         load;
    logic         fall_detected;
    logic         freefall_active;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_LOW_THRESHOLD_SQ:     cfg_next.low_threshold_sq = cfg_data;
                REG_HIGH_THRESHOLD_SQ:    cfg_next.high_threshold_sq = cfg_data;
                REG_FREEFALL_COUNT_LIMIT: cfg_next.freefall_count_limit = cfg_data[CNT_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_threshold_sq     <= LOW_THRESHOLD_SQ_RESET;
            cfg_reg.high_threshold_sq    <= HIGH_THRESHOLD_SQ_RESET;
            cfg_reg.freefall_count_limit <= FREEFALL_COUNT_LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign advance   = !m_tvalid || m_tready;
    assign s_tready  = !sq_valid || advance;
    assign load      = s_tvalid && s_tready;

    ffd_square u_square (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .advance  (advance),
        .accel_x  (s_tdata[AXIS_W-1:0]),
        .accel_y  (s_tdata[2*AXIS_W-1:AXIS_W]),
        .accel_z  (s_tdata[3*AXIS_W-1:2*AXIS_W]),
        .sq_valid (sq_valid),
        .squares  (squares)
    );

    ffd_decide u_decide (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .sq_valid        (sq_valid),
        .squares         (squares),
        .cfg             (cfg_reg),
        .res_valid       (m_tvalid),
        .fall_detected   (fall_detected),
        .freefall_active (freefall_active)
    );

    assign m_tdata = {{(M_TDATA_W-2){1'b0}}, freefall_active, fall_detected};

endmodule

// File: hw/rtl/ffd_checker.sv
module ffd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ffd_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ffd_pkg::*;

    // nothing left valid straight out of reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a reported fall always disarms the flag
    a_fall_clears_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> !m_tdata[1])
        else $error("fall reported with flag still set");

    // a draining output never blocks intake
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("intake stalled while output drains");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind freefall_impact_fall_detector_unit ffd_checker u_ffd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/freefall_impact_fall_detector_unit_tb.sv
module freefall_impact_fall_detector_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ffd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 2'd3;
    localparam logic [THR_W-1:0]     THR_MAX       = 32'hC000_0000;
    localparam int unsigned          PHASE_ITEMS   = 85;
    localparam int unsigned          PHASE_COUNT   = 12;
    localparam int unsigned          CYCLE_LIMIT   = 400000;
    localparam int unsigned          REPORT_LIMIT  = 10;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
    } axes_t;

    typedef struct packed {
        logic fall;
        logic freefall;
    } verdict_t;

    typedef struct {
        bit                     is_write;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        axes_t                  a;
        bit                     known;
        verdict_t               v;
    } step_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // detector image
    logic [THR_W-1:0]  thr_low;
    logic [THR_W-1:0]  thr_high;
    logic [CNT_W-1:0]  run_limit;
    logic [CNT_W-1:0]  low_run;
    logic              armed;

    verdict_t     expected_verdicts[$];
    step_t        directed_steps[$];
    int unsigned  mismatches;
    int unsigned  samples_sent;
    int unsigned  verdicts_seen;
    int unsigned  falls_seen;
    int unsigned  reg_writes;
    int unsigned  cycle_count;
    bit           no_idle;

    freefall_impact_fall_detector_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic int unsigned idle_cycles();
        if (no_idle) begin
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    function automatic logic [33:0] magnitude_sq(axes_t a);
        longint mx;
        longint my;
        longint mz;
        mx = (a.x < 0) ? -longint'(a.x) : longint'(a.x);
        my = (a.y < 0) ? -longint'(a.y) : longint'(a.y);
        mz = (a.z < 0) ? -longint'(a.z) : longint'(a.z);
        return 34'(mx * mx + my * my + mz * mz);
    endfunction

    function automatic verdict_t predict_verdict(axes_t a);
        logic [33:0] s;
        verdict_t    v;
        s = magnitude_sq(a);
        v.fall = 1'b0;
        if (s < {2'b00, thr_low}) begin
            if (low_run != CNT_MAX) begin
                low_run = low_run + 1'b1;
            end
            if (low_run > run_limit) begin
                armed = 1'b1;
            end
        end else if (s > {2'b00, thr_high} && armed) begin
            v.fall  = 1'b1;
            low_run = '0;
            armed   = 1'b0;
        end else begin
            low_run = '0;
            armed   = 1'b0;
        end
        v.freefall = armed;
        return v;
    endfunction

    function automatic int unsigned isqrt(longint unsigned val);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= val) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return int'(lo);
    endfunction

    function automatic logic signed [AXIS_W-1:0] axis_of(int unsigned mag);
        if (mag >= 32768) begin
            return -16'sd32768;
        end
        if ($urandom_range(0, 1) == 1) begin
            return -$signed(16'(mag));
        end
        return $signed(16'(mag));
    endfunction

    function automatic axes_t pick_noise();
        axes_t a;
        a.x = 16'($urandom);
        a.y = 16'($urandom);
        a.z = 16'($urandom);
        return a;
    endfunction

    function automatic axes_t pick_low();
        axes_t       a;
        int unsigned lim;
        if (thr_low == 0) begin
            return pick_noise();
        end
        lim = isqrt(thr_low);
        if (lim > 32768) begin
            lim = 32768;
        end
        repeat (20) begin
            a.x = axis_of($urandom_range(0, lim));
            a.y = axis_of($urandom_range(0, lim));
            a.z = axis_of($urandom_range(0, lim));
            if (magnitude_sq(a) < {2'b00, thr_low}) begin
                return a;
            end
        end
        return '0;
    endfunction

    function automatic axes_t pick_high();
        axes_t       a;
        int unsigned lo;
        lo = isqrt(thr_high / 3);
        if (lo > 32768) begin
            lo = 32768;
        end
        repeat (20) begin
            a.x = axis_of($urandom_range(lo, 32768));
            a.y = axis_of($urandom_range(lo, 32768));
            a.z = axis_of($urandom_range(lo, 32768));
            if (magnitude_sq(a) > {2'b00, thr_high}) begin
                return a;
            end
        end
        a.x = -16'sd32768;
        a.y = -16'sd32768;
        a.z = -16'sd32768;
        return a;
    endfunction

    function automatic axes_t pick_edge(logic [THR_W-1:0] thr);
        axes_t       a;
        int unsigned m;
        m = isqrt(thr);
        if (m > 32768) begin
            m = 32768;
        end
        a   = '0;
        a.x = axis_of(m);
        return a;
    endfunction

    task automatic send_sample(axes_t a, bit known, verdict_t typed);
        verdict_t    v;
        int unsigned gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {a.z, a.y, a.x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        v = predict_verdict(a);
        expected_verdicts.push_back(known ? typed : v);
        samples_sent++;
        gap = idle_cycles();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic send_axes(axes_t a);
        send_sample(a, 1'b0, '0);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_LOW_THRESHOLD_SQ:     thr_low   = data;
            REG_HIGH_THRESHOLD_SQ:    thr_high  = data;
            REG_FREEFALL_COUNT_LIMIT: run_limit = data[CNT_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic void add_sample(int x, int y, int z);
        step_t st;
        st          = '{default: '0};
        st.a.x      = 16'(x);
        st.a.y      = 16'(y);
        st.a.z      = 16'(z);
        directed_steps.push_back(st);
    endfunction

    function automatic void add_known(int x, int y, int z, bit fall, bit freefall);
        step_t st;
        st            = '{default: '0};
        st.a.x        = 16'(x);
        st.a.y        = 16'(y);
        st.a.z        = 16'(z);
        st.known      = 1'b1;
        st.v.fall     = fall;
        st.v.freefall = freefall;
        directed_steps.push_back(st);
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        step_t st;
        st          = '{default: '0};
        st.is_write = 1'b1;
        st.idx      = idx;
        st.data     = data;
        directed_steps.push_back(st);
    endfunction

    task automatic run_phase(int unsigned target);
        int unsigned first;
        int unsigned run_len;
        int unsigned base;
        int unsigned i;
        axes_t       a;
        first = samples_sent;
        while (samples_sent - first < target) begin
            if ($urandom_range(0, 9) < 7) begin
                base = run_limit;
                if ($urandom_range(0, 9) < 2) begin
                    run_len = $urandom_range(0, base);
                end else begin
                    run_len = base + 1 + $urandom_range(0, 3);
                end
                for (i = 0; i < run_len; i++) begin
                    send_axes(pick_low());
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: a = pick_high();
                    6, 7:             a = pick_noise();
                    8:                a = pick_edge(thr_high);
                    default:          a = pick_edge(thr_low);
                endcase
                send_axes(a);
            end else begin
                repeat ($urandom_range(1, 4)) send_axes(pick_noise());
            end
        end
    endtask

    // result sink with random back-pressure
    initial begin
        int unsigned gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        m_tready = 1'b1;
        forever begin
            gap = idle_cycles();
            if (gap > 0) begin
                @(negedge aclk);
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
                m_tready = 1'b1;
            end
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            verdicts_seen++;
            if (m_tdata[0]) begin
                falls_seen++;
            end
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected result: fall %0b freefall %0b", m_tdata[0], m_tdata[1]);
                end
            end else begin
                want = expected_verdicts.pop_front();
                if (m_tdata[0] !== want.fall || m_tdata[1] !== want.freefall) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("mismatch at result %0d: expected fall %0b freefall %0b, got fall %0b freefall %0b",
                                 verdicts_seen, want.fall, want.freefall, m_tdata[0], m_tdata[1]);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_verdicts.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [THR_W-1:0]  lo;
        logic [THR_W-1:0]  hi;
        logic [CNT_W-1:0]  lim;
        int unsigned       p;
        int unsigned       k;
        int unsigned       settle;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        no_idle       = 1'b0;
        mismatches    = 0;
        samples_sent  = 0;
        verdicts_seen = 0;
        falls_seen    = 0;
        reg_writes    = 0;
        cycle_count   = 0;
        thr_low       = LOW_THRESHOLD_SQ_RESET;
        thr_high      = HIGH_THRESHOLD_SQ_RESET;
        run_limit     = FREEFALL_COUNT_LIMIT_RESET;
        low_run       = '0;
        armed         = 1'b0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        add_known(-32768, -32768, -32768, 1'b0, 1'b0);
        add_known(32767, 32767, 32767, 1'b0, 1'b0);
        add_known(0, 0, 0, 1'b0, 1'b0);
        add_sample(1023, -1, 0);
        add_sample(0, -1024, 0);
        add_write(REG_FREEFALL_COUNT_LIMIT, 32'd0);
        add_sample(-1, 1, -1);
        add_sample(0, 7168, 0);
        add_sample(0, 0, 0);
        add_known(-32768, -32768, -32768, 1'b1, 1'b0);
        add_sample(0, 0, 0);
        add_write(REG_LOW_THRESHOLD_SQ, 32'd0);
        add_write(REG_HIGH_THRESHOLD_SQ, 32'd0);
        add_sample(0, 0, 0);
        add_sample(0, 0, 1);
        // overlapping thresholds, low rule wins
        add_write(REG_LOW_THRESHOLD_SQ, THR_MAX);
        add_sample(32767, -32768, 5);
        add_known(-32768, -32768, -32768, 1'b1, 1'b0);
        add_write(REG_FREEFALL_COUNT_LIMIT, 32'd255);
        add_sample(0, 0, 0);
        // limit lowered to arm the flag, then raised while already armed
        add_write(REG_FREEFALL_COUNT_LIMIT, 32'd3);
        add_sample(0, 0, 0);
        add_sample(0, 0, 0);
        add_sample(0, 0, 0);
        add_write(REG_FREEFALL_COUNT_LIMIT, 32'd200);
        add_sample(0, 0, 0);
        add_sample(-32768, -32768, -32768);
        add_write(REG_SPARE, 32'hFFFF_FFFF);
        add_write(REG_LOW_THRESHOLD_SQ, LOW_THRESHOLD_SQ_RESET);
        add_write(REG_HIGH_THRESHOLD_SQ, HIGH_THRESHOLD_SQ_RESET);
        add_write(REG_FREEFALL_COUNT_LIMIT, 32'(FREEFALL_COUNT_LIMIT_RESET));

        for (k = 0; k < directed_steps.size(); k++) begin
            if (directed_steps[k].is_write) begin
                wait_idle();
                write_reg(directed_steps[k].idx, directed_steps[k].data);
            end else begin
                send_sample(directed_steps[k].a, directed_steps[k].known, directed_steps[k].v);
            end
        end

        for (p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin
                    lo  = LOW_THRESHOLD_SQ_RESET;
                    hi  = HIGH_THRESHOLD_SQ_RESET;
                    lim = FREEFALL_COUNT_LIMIT_RESET;
                end
                1: begin
                    lo  = '0;
                    hi  = '0;
                    lim = '0;
                end
                2: begin
                    lo  = THR_MAX;
                    hi  = THR_MAX;
                    lim = 8'($urandom_range(0, 8));
                end
                3: begin
                    lo  = THR_MAX;
                    hi  = '0;
                    lim = 8'($urandom_range(0, 3));
                end
                4: begin
                    lo  = LOW_THRESHOLD_SQ_RESET;
                    hi  = HIGH_THRESHOLD_SQ_RESET;
                    lim = 8'd254;
                end
                5: begin
                    lo  = LOW_THRESHOLD_SQ_RESET;
                    hi  = HIGH_THRESHOLD_SQ_RESET;
                    lim = CNT_MAX;
                end
                default: begin
                    lim = 8'($urandom_range(0, 20));
                    if ($urandom_range(0, 3) == 0) begin
                        lo = $urandom_range(0, THR_MAX);
                        hi = $urandom_range(0, THR_MAX);
                    end else begin
                        lo = $urandom_range(1, 60000000);
                        hi = lo + $urandom_range(0, 400000000);
                    end
                end
            endcase
            wait_idle();
            no_idle = (p % 4 == 3);
            write_reg(REG_LOW_THRESHOLD_SQ, lo);
            write_reg(REG_HIGH_THRESHOLD_SQ, hi);
            write_reg(REG_FREEFALL_COUNT_LIMIT, 32'(lim));
            run_phase(PHASE_ITEMS);
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_verdicts.size() != 0) @(posedge aclk);
        settle = 0;
        while (settle < 10) begin
            @(posedge aclk);
            settle++;
        end

        $display("%0d samples over %0d register writes, including threshold extremes and long runs",
                 samples_sent, reg_writes);
        $display("%0d results checked, %0d falls reported, %0d mismatches",
                 verdicts_seen, falls_seen, mismatches);
        if (mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: freefall_impact_fall_detector_unit.f
hw/rtl/ffd_pkg.sv
hw/rtl/ffd_square.sv
hw/rtl/ffd_decide.sv
hw/rtl/freefall_impact_fall_detector_unit.sv
hw/rtl/ffd_checker.sv
tb/freefall_impact_fall_detector_unit_tb.sv
